[sv/su3_pkg.sv]
package su3_pkg;

    localparam int PART_WIDTH = 32;
    localparam int FRAC_BITS  = PART_WIDTH - 5;
    localparam int PROD_W     = 2 * PART_WIDTH;
    localparam int ACC_W      = PROD_W + 4;

    typedef logic signed [PART_WIDTH-1:0] part_t;
    typedef logic signed [PROD_W-1:0]     prod_t;
    typedef logic signed [ACC_W-1:0]      acc_t;

    typedef struct packed {
        part_t re;
        part_t im;
    } cpx_t;

    localparam acc_t HALF_LSB = acc_t'(1) <<< (FRAC_BITS - 1);
    localparam acc_t PART_MAX = (acc_t'(1) <<< (PART_WIDTH - 1)) - acc_t'(1);
    localparam acc_t PART_MIN = -(acc_t'(1) <<< (PART_WIDTH - 1));

    // round half up, then clamp to the signed part range
    function automatic part_t round_sat(input acc_t x);
        acc_t t;
        acc_t s;
        begin
            t = x + HALF_LSB;
            s = t >>> FRAC_BITS;
            if (s > PART_MAX)
            begin
                round_sat = part_t'(PART_MAX);
            end
            else if (s < PART_MIN)
            begin
                round_sat = part_t'(PART_MIN);
            end
            else
            begin
                round_sat = part_t'(s);
            end
        end
    endfunction

    // a part sits in the low PART_WIDTH bits of a 32-bit half
    function automatic cpx_t unpack(input logic [63:0] w);
        cpx_t c;
        begin
            c.re = part_t'(w[32 +: PART_WIDTH]);
            c.im = part_t'(w[0 +: PART_WIDTH]);
            unpack = c;
        end
    endfunction

    function automatic logic [63:0] pack(input cpx_t c);
        logic signed [31:0] r;
        logic signed [31:0] i;
        begin
            r = 32'(c.re);
            i = 32'(c.im);
            pack = {r, i};
        end
    endfunction

endpackage

[sv/su3_link_vector_multiply.sv]
// SU(3) link times color vector with twelve-number link storage. Each transfer
// brings rows 0 and 1 of a complex 3x3 link, a complex 3-vector and two flags;
// row 2 is rebuilt as the conjugated cross product of rows 0 and 1 (negated
// when row3_negate is set), and the block returns M*v, or M^H*v when
// use_adjoint is set. Parts are signed Q4.27 (real in bits 63:32, imaginary in
// 31:0); row 2 and every result part are rounded half up once and saturated.
// A new item is taken every cycle unless the output stalls. The pipeline:
// input register, cross-product multipliers, cross-product sums, row-2
// rounding, matrix-vector multipliers, sums, and rounding into the output
// register. The whole pipe holds while the output register is full and not
// taken, so nothing is dropped or repeated.
module su3_link_vector_multiply
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // link_r0_c0, link_r0_c1, link_r0_c2, link_r1_c0, link_r1_c1, link_r1_c2,
    // vec_c0, vec_c1, vec_c2 (64 bits each)
    input  logic [575:0] s_axis_tdata,
    // row3_negate, use_adjoint
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_c0, out_c1, out_c2 (64 bits each)
    output logic [191:0] m_axis_tdata
);

    localparam int NSTG = 7;

    // cross-product operand indexes into rows 0/1 (r*3+c): conj(a*b - c*d)
    localparam int IA [3] = '{1, 2, 0};
    localparam int IB [3] = '{5, 3, 4};
    localparam int IC [3] = '{2, 0, 1};
    localparam int ID [3] = '{4, 5, 3};

    logic [NSTG-1:0] vld_reg;
    logic            adv;

    // stage 0: unpacked input
    su3_pkg::cpx_t m0_reg [6];
    su3_pkg::cpx_t v0_reg [3];
    logic          neg0_reg, adj0_reg;
    // stage 1: cross products
    su3_pkg::prod_t p1_reg [3][8];
    su3_pkg::prod_t p1_next [3][8];
    su3_pkg::cpx_t  m1_reg [6];
    su3_pkg::cpx_t  v1_reg [3];
    logic           neg1_reg, adj1_reg;
    // stage 2: cross sums
    su3_pkg::acc_t  s2_reg [3][2];
    su3_pkg::acc_t  s2_next [3][2];
    su3_pkg::cpx_t  m2_reg [6];
    su3_pkg::cpx_t  v2_reg [3];
    logic           adj2_reg;
    // stage 3: full matrix
    su3_pkg::cpx_t  m3_reg [9];
    su3_pkg::cpx_t  m3_next [9];
    su3_pkg::cpx_t  v3_reg [3];
    logic           adj3_reg;
    // stage 4: matrix-vector products, per row: er*vr, ei*vi, er*vi, ei*vr
    su3_pkg::prod_t p4_reg [3][3][4];
    su3_pkg::prod_t p4_next [3][3][4];
    logic           adj4_reg;
    // stage 5: row sums
    su3_pkg::acc_t  s5_reg [3][2];
    su3_pkg::acc_t  s5_next [3][2];
    // stage 6: output
    logic [191:0]   out_reg;
    logic [191:0]   out_next;

    assign adv           = !vld_reg[NSTG-1] || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = vld_reg[NSTG-1];
    assign m_axis_tdata  = out_reg;

    always_comb
    begin
        for (int e = 0; e < 3; e++)
        begin
            p1_next[e][0] = m0_reg[IA[e]].re * m0_reg[IB[e]].re;
            p1_next[e][1] = m0_reg[IA[e]].im * m0_reg[IB[e]].im;
            p1_next[e][2] = m0_reg[IC[e]].re * m0_reg[ID[e]].re;
            p1_next[e][3] = m0_reg[IC[e]].im * m0_reg[ID[e]].im;
            p1_next[e][4] = m0_reg[IA[e]].re * m0_reg[IB[e]].im;
            p1_next[e][5] = m0_reg[IA[e]].im * m0_reg[IB[e]].re;
            p1_next[e][6] = m0_reg[IC[e]].re * m0_reg[ID[e]].im;
            p1_next[e][7] = m0_reg[IC[e]].im * m0_reg[ID[e]].re;
        end
    end

    always_comb
    begin
        for (int e = 0; e < 3; e++)
        begin
            s2_next[e][0] = su3_pkg::acc_t'(p1_reg[e][0]) - su3_pkg::acc_t'(p1_reg[e][1])
                          - su3_pkg::acc_t'(p1_reg[e][2]) + su3_pkg::acc_t'(p1_reg[e][3]);
            s2_next[e][1] = su3_pkg::acc_t'(p1_reg[e][6]) + su3_pkg::acc_t'(p1_reg[e][7])
                          - su3_pkg::acc_t'(p1_reg[e][4]) - su3_pkg::acc_t'(p1_reg[e][5]);
            if (neg1_reg)
            begin
                s2_next[e][0] = -s2_next[e][0];
                s2_next[e][1] = -s2_next[e][1];
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < 6; k++)
        begin
            m3_next[k] = m2_reg[k];
        end
        for (int e = 0; e < 3; e++)
        begin
            m3_next[6 + e].re = su3_pkg::round_sat(s2_reg[e][0]);
            m3_next[6 + e].im = su3_pkg::round_sat(s2_reg[e][1]);
        end
    end

    // adjoint picks the transposed element; its conjugate is folded into the sums
    always_comb
    begin
        su3_pkg::cpx_t el;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                el = adj3_reg ? m3_reg[c*3 + r] : m3_reg[r*3 + c];
                p4_next[r][c][0] = el.re * v3_reg[c].re;
                p4_next[r][c][1] = el.im * v3_reg[c].im;
                p4_next[r][c][2] = el.re * v3_reg[c].im;
                p4_next[r][c][3] = el.im * v3_reg[c].re;
            end
        end
    end

    always_comb
    begin
        su3_pkg::acc_t a_re, b_re, a_im, b_im;
        for (int r = 0; r < 3; r++)
        begin
            a_re = '0;
            b_re = '0;
            a_im = '0;
            b_im = '0;
            for (int c = 0; c < 3; c++)
            begin
                a_re = a_re + su3_pkg::acc_t'(p4_reg[r][c][0]);
                b_re = b_re + su3_pkg::acc_t'(p4_reg[r][c][1]);
                a_im = a_im + su3_pkg::acc_t'(p4_reg[r][c][2]);
                b_im = b_im + su3_pkg::acc_t'(p4_reg[r][c][3]);
            end
            s5_next[r][0] = adj4_reg ? a_re + b_re : a_re - b_re;
            s5_next[r][1] = adj4_reg ? a_im - b_im : a_im + b_im;
        end
    end

    always_comb
    begin
        su3_pkg::cpx_t res;
        for (int r = 0; r < 3; r++)
        begin
            res.re = su3_pkg::round_sat(s5_reg[r][0]);
            res.im = su3_pkg::round_sat(s5_reg[r][1]);
            out_next[r*64 +: 64] = su3_pkg::pack(res);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NSTG-2:0], s_axis_tvalid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 6; k++)
            begin
                m0_reg[k] <= su3_pkg::unpack(s_axis_tdata[k*64 +: 64]);
            end
            for (int c = 0; c < 3; c++)
            begin
                v0_reg[c] <= su3_pkg::unpack(s_axis_tdata[(6 + c)*64 +: 64]);
            end
            neg0_reg <= s_axis_tuser[0];
            adj0_reg <= s_axis_tuser[1];

            p1_reg   <= p1_next;
            m1_reg   <= m0_reg;
            v1_reg   <= v0_reg;
            neg1_reg <= neg0_reg;
            adj1_reg <= adj0_reg;

            s2_reg   <= s2_next;
            m2_reg   <= m1_reg;
            v2_reg   <= v1_reg;
            adj2_reg <= adj1_reg;

            m3_reg   <= m3_next;
            v3_reg   <= v2_reg;
            adj3_reg <= adj2_reg;

            p4_reg   <= p4_next;
            adj4_reg <= adj3_reg;

            s5_reg   <= s5_next;

            out_reg  <= out_next;
        end
    end

endmodule
